### hdl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window minimum filter.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int SAMPLE_W           = 32;
   localparam int WINLEN_W           = 7;
   localparam int WINDOW_MAX_DEFAULT = 64;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;

   // register index, taken from the word address bits
   localparam logic REG_WINDOW_LENGTH = 1'b0;

   localparam logic [WINLEN_W-1:0] WINLEN_RESET = 7'd1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // control handed to every cell of the row
   typedef struct packed {
      logic       load;
      sample_type sample;
   } cell_ctrl_type;

endpackage

### hdl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One cell of the minimum row: holds the minimum of the last k+1 samples,
// built from the new sample and the left neighbor's previous minimum.
// ----------------------------------------------------------------------------
module swm_cell (
   input  logic                  clock,
   input  swm_pkg::cell_ctrl_type ctrl,
   input  swm_pkg::sample_type   prev_min,
   output swm_pkg::sample_type   cell_min
);
   import swm_pkg::*;

   sample_type min_ff;
   sample_type min_in;

   always_comb begin
      if (ctrl.sample < prev_min) begin
         min_in = ctrl.sample;
      end else begin
         min_in = prev_min;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         min_ff <= min_in;
      end
   end

   assign cell_min = min_ff;

endmodule

### hdl/sliding_window_minimum.sv
// Throughput: one sample per cycle unless rsp_ready stalls; a row of WINDOW_MAX
// cells updates the running minima of every window length in the accept cycle,
// the sample is held pending, and one select stage picks the cell for the
// current window into the output word once the result channel is free.
// Reset: synchronous, active high; clears fill count, window length (to 1)
// and handshake state; no clearing pass, cells count as filled on arrival.
// ----------------------------------------------------------------------------
// sliding_window_minimum
// Sliding window minimum filter over the last window_length samples.
// ----------------------------------------------------------------------------
module sliding_window_minimum #(
   parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] req_sample,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [swm_pkg::SAMPLE_W-1:0] rsp_window_min,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import swm_pkg::*;

   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W = (CNT_W > WINLEN_W) ? CNT_W : WINLEN_W;
   localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(WINDOW_MAX);

   // register port
   logic [WINLEN_W-1:0] winlen_ff, winlen_in;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      winlen_in = winlen_ff;
      if (csr_write && (paddr[2] == REG_WINDOW_LENGTH)) begin
         winlen_in = pwdata[WINLEN_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_WINDOW_LENGTH) begin
         prdata = CSR_DATA_W'(winlen_ff);
      end
   end

   // handshake and fill control
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             out_free;
   logic             req_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pend_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      pend_in      = req_fire || (pend_ff && !out_free);
      rsp_valid_in = rsp_valid_ff;
      if (pend_ff && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      fill_in = fill_ff;
      if (req_fire && (fill_ff != FILL_FULL)) begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         winlen_ff    <= WINLEN_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         winlen_ff    <= winlen_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   // row of cells; cell k holds the minimum of the last k+1 samples
   cell_ctrl_type ctrl;
   sample_type    cell_min [WINDOW_MAX];

   assign ctrl.load   = req_fire;
   assign ctrl.sample = req_sample;

   for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
      if (k == 0) begin : g_head
         swm_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .prev_min (req_sample),
            .cell_min (cell_min[k])
         );
      end else begin : g_body
         swm_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .prev_min (cell_min[k-1]),
            .cell_min (cell_min[k])
         );
      end
   end

   // window length clamped to at least one and to the filled entries
   logic [CMP_W-1:0] win_req;
   logic [CMP_W-1:0] win_eff;
   logic [IDX_W-1:0] sel_idx;

   always_comb begin
      win_req = CMP_W'(winlen_ff);
      if (winlen_ff == '0) begin
         win_req = CMP_W'(1);
      end
      win_eff = win_req;
      if (win_req > CMP_W'(fill_ff)) begin
         win_eff = CMP_W'(fill_ff);
      end
      sel_idx = IDX_W'(win_eff - CMP_W'(1));
   end

   sample_type min_ff, min_in;

   always_comb begin
      min_in = min_ff;
      if (pend_ff && out_free) begin
         min_in = cell_min[sel_idx];
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_min = min_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fill count above window maximum");

   a_fire_pends: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> pend_ff)
      else $error("accepted sample not pending for select");

   a_rsp_from_pend: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pend_ff))
      else $error("result raised without a pending sample");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && pend_ff && !out_free))
      else $error("sample accepted over a blocked pending one");

   a_filled_when_pend: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (fill_ff != '0))
      else $error("pending sample with empty history");
`endif

endmodule
